>>> design/gswc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gswc_pkg
// Shared types and constants of the gyro swing window classifier.
// ----------------------------------------------------------------------------
package gswc_pkg;

    localparam int ACC_WIDTH_DEF = 48;

    localparam int RATE_W  = 16;
    localparam int STEP_W  = 16;
    localparam int CFG_W   = 15;
    localparam int CFG_IDX_W = 2;
    localparam int SQ_W    = 32;
    localparam int CFG_SQ_W = 2 * CFG_W;
    localparam int ANGLE_SHIFT = 16;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_BEGIN  = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    localparam logic [2:0] DIR_NONE = 3'd0;
    localparam logic [2:0] DIR_UP   = 3'd1;
    localparam logic [2:0] DIR_DOWN = 3'd2;
    localparam logic [2:0] DIR_L2R  = 3'd3;
    localparam logic [2:0] DIR_R2L  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_START_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PEAK_SPEED  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE       = 2'd2;

    localparam logic [CFG_SQ_W-1:0] START_SQ_RESET    = 30'd230400;
    localparam logic [CFG_SQ_W-1:0] MIN_PEAK_SQ_RESET = 30'd1638400;
    localparam logic [CFG_W-1:0]    MIN_ANGLE_RESET   = 15'd400;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [RATE_W-1:0] rate_x;
        logic signed [RATE_W-1:0] rate_y;
        logic signed [RATE_W-1:0] rate_z;
        logic [STEP_W-1:0]        step_time;
    } t_in_item;

    typedef struct packed {
        logic       swing_found;
        logic [2:0] direction;
    } t_out_item;

endpackage

>>> design/gswc_axis_acc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gswc_axis_acc
// One axis of angle integration: adds rate times step time to the
// accumulator and saturates at the accumulator limits.
// ----------------------------------------------------------------------------
module gswc_axis_acc #(
    parameter int ACC_WIDTH = gswc_pkg::ACC_WIDTH_DEF
) (
    input  logic signed [ACC_WIDTH-1:0]           i_acc,
    input  logic signed [gswc_pkg::RATE_W-1:0]    i_rate,
    input  logic        [gswc_pkg::STEP_W-1:0]    i_step_time,
    output logic signed [ACC_WIDTH-1:0]           o_acc
);

    localparam int PROD_W = gswc_pkg::RATE_W + gswc_pkg::STEP_W + 1;

    logic signed [PROD_W-1:0]    prod;
    logic signed [ACC_WIDTH:0]   sum;
    logic [ACC_WIDTH-1:0]        acc_max;
    logic [ACC_WIDTH-1:0]        acc_min;

    assign prod    = PROD_W'(i_rate) * $signed({1'b0, i_step_time});
    assign sum     = {i_acc[ACC_WIDTH-1], i_acc}
                   + {{(ACC_WIDTH + 1 - PROD_W){prod[PROD_W-1]}}, prod};
    assign acc_max = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    assign acc_min = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    always_comb begin
        if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
            o_acc = sum[ACC_WIDTH] ? $signed(acc_min) : $signed(acc_max);
        end else begin
            o_acc = sum[ACC_WIDTH-1:0];
        end
    end

endmodule

>>> design/gyro_swing_window_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_swing_window_classifier_top
// Integrates gyro rates over a begin/end window and classifies the swing
// direction from the dominant axis angle when the window closes.
// ----------------------------------------------------------------------------
// One beat is taken every cycle unless the input stalls. A beat is registered
// on entry; the accumulate, square and compare logic then updates the window
// state from it and, for an end beat, loads the result register. Only an end
// beat waits, and only while the result register is full and stalled; the
// input stalls during that wait.
// Threshold squares are formed when a register is written.
// ----------------------------------------------------------------------------
module gyro_swing_window_classifier_top #(
    parameter int ACC_WIDTH = gswc_pkg::ACC_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  gswc_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output gswc_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gswc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gswc_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int SQ_W = gswc_pkg::SQ_W;

    logic                         r_in_valid;
    gswc_pkg::t_in_item           r_in_item;
    logic                         r_out_valid;
    gswc_pkg::t_out_item          r_out_item;

    logic [gswc_pkg::CFG_SQ_W-1:0] r_start_sq;
    logic [gswc_pkg::CFG_SQ_W-1:0] r_min_peak_sq;
    logic [gswc_pkg::CFG_W-1:0]    r_min_angle;

    logic signed [ACC_WIDTH-1:0]  r_angle_x, r_angle_y, r_angle_z;
    logic signed [ACC_WIDTH-1:0]  n_angle_x, n_angle_y, n_angle_z;
    logic [SQ_W-1:0]              r_peak_sq, n_peak_sq;
    logic                         r_strong, n_strong;
    logic                         r_window, n_window;
    gswc_pkg::t_out_item          n_out_item;

    logic signed [ACC_WIDTH-1:0]  acc_x, acc_y, acc_z;
    logic signed [SQ_W-1:0]       prod_x, prod_y, prod_z;
    logic [SQ_W-1:0]              sq_sum;
    logic [ACC_WIDTH-1:0]         mag_x, mag_y, mag_z;
    logic [ACC_WIDTH-1:0]         best;
    logic [1:0]                   axis;
    logic [ACC_WIDTH-1:0]         angle_floor;
    logic [gswc_pkg::CFG_SQ_W-1:0] cfg_sq;
    logic [gswc_pkg::CFG_SQ_W-1:0] cfg_wide;

    logic                         is_end;
    logic                         advance;
    logic                         take_in;
    logic                         out_taken;

    gswc_axis_acc #(.ACC_WIDTH(ACC_WIDTH)) u_acc_x (
        .i_acc(r_angle_x), .i_rate(r_in_item.rate_x),
        .i_step_time(r_in_item.step_time), .o_acc(acc_x)
    );
    gswc_axis_acc #(.ACC_WIDTH(ACC_WIDTH)) u_acc_y (
        .i_acc(r_angle_y), .i_rate(r_in_item.rate_y),
        .i_step_time(r_in_item.step_time), .o_acc(acc_y)
    );
    gswc_axis_acc #(.ACC_WIDTH(ACC_WIDTH)) u_acc_z (
        .i_acc(r_angle_z), .i_rate(r_in_item.rate_z),
        .i_step_time(r_in_item.step_time), .o_acc(acc_z)
    );

    assign is_end     = (r_in_item.kind == gswc_pkg::KIND_END);
    assign out_taken  = r_out_valid && !i_out_stall;
    assign advance    = r_in_valid && (!is_end || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign take_in    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    assign cfg_wide = {{gswc_pkg::CFG_W{1'b0}}, i_cfg_data};
    assign cfg_sq   = cfg_wide * cfg_wide;

    assign prod_x = SQ_W'(r_in_item.rate_x) * SQ_W'(r_in_item.rate_x);
    assign prod_y = SQ_W'(r_in_item.rate_y) * SQ_W'(r_in_item.rate_y);
    assign prod_z = SQ_W'(r_in_item.rate_z) * SQ_W'(r_in_item.rate_z);
    assign sq_sum = $unsigned(prod_x) + $unsigned(prod_y) + $unsigned(prod_z);

    assign mag_x = r_angle_x[ACC_WIDTH-1] ? (~r_angle_x + 1'b1) : r_angle_x;
    assign mag_y = r_angle_y[ACC_WIDTH-1] ? (~r_angle_y + 1'b1) : r_angle_y;
    assign mag_z = r_angle_z[ACC_WIDTH-1] ? (~r_angle_z + 1'b1) : r_angle_z;
    assign angle_floor = {{(ACC_WIDTH - gswc_pkg::CFG_W - gswc_pkg::ANGLE_SHIFT){1'b0}},
                          r_min_angle, {gswc_pkg::ANGLE_SHIFT{1'b0}}};

    always_comb begin
        best = mag_x;
        axis = 2'd0;
        if (mag_y > best) begin
            best = mag_y;
            axis = 2'd1;
        end
        if (mag_z > best) begin
            best = mag_z;
            axis = 2'd2;
        end
    end

    always_comb begin
        n_angle_x  = r_angle_x;
        n_angle_y  = r_angle_y;
        n_angle_z  = r_angle_z;
        n_peak_sq  = r_peak_sq;
        n_strong   = r_strong;
        n_window   = r_window;
        n_out_item = '{swing_found: 1'b0, direction: gswc_pkg::DIR_NONE};
        case (r_in_item.kind)
            gswc_pkg::KIND_BEGIN: begin
                n_angle_x = '0;
                n_angle_y = '0;
                n_angle_z = '0;
                n_peak_sq = '0;
                n_strong  = 1'b0;
                n_window  = 1'b1;
            end
            gswc_pkg::KIND_SAMPLE: begin
                if (r_window && (r_in_item.step_time != '0)) begin
                    n_angle_x = acc_x;
                    n_angle_y = acc_y;
                    n_angle_z = acc_z;
                    if (sq_sum > r_peak_sq) begin
                        n_peak_sq = sq_sum;
                    end
                    if (sq_sum > SQ_W'(r_start_sq)) begin
                        n_strong = 1'b1;
                    end
                end
            end
            gswc_pkg::KIND_END: begin
                n_window = 1'b0;
                if (r_window && r_strong && (r_peak_sq >= SQ_W'(r_min_peak_sq))
                        && (best >= angle_floor)) begin
                    case (axis)
                        2'd0: begin
                            n_out_item.swing_found = 1'b1;
                            n_out_item.direction =
                                (!r_angle_x[ACC_WIDTH-1] && (r_angle_x != '0))
                                ? gswc_pkg::DIR_UP : gswc_pkg::DIR_DOWN;
                        end
                        2'd1: begin
                            n_out_item.swing_found = 1'b1;
                            n_out_item.direction =
                                (!r_angle_y[ACC_WIDTH-1] && (r_angle_y != '0))
                                ? gswc_pkg::DIR_L2R : gswc_pkg::DIR_R2L;
                        end
                        default: begin
                            n_out_item.swing_found = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                n_window = r_window;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_window      <= 1'b0;
            r_strong      <= 1'b0;
            r_peak_sq     <= '0;
            r_angle_x     <= '0;
            r_angle_y     <= '0;
            r_angle_z     <= '0;
            r_start_sq    <= gswc_pkg::START_SQ_RESET;
            r_min_peak_sq <= gswc_pkg::MIN_PEAK_SQ_RESET;
            r_min_angle   <= gswc_pkg::MIN_ANGLE_RESET;
        end else begin
            if (take_in) begin
                r_in_valid <= 1'b1;
                r_in_item  <= i_in_item;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_angle_x <= n_angle_x;
                r_angle_y <= n_angle_y;
                r_angle_z <= n_angle_z;
                r_peak_sq <= n_peak_sq;
                r_strong  <= n_strong;
                r_window  <= n_window;
            end

            if (advance && is_end) begin
                r_out_valid <= 1'b1;
                r_out_item  <= n_out_item;
            end else if (out_taken) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    gswc_pkg::REG_START_THRESHOLD: r_start_sq    <= cfg_sq;
                    gswc_pkg::REG_MIN_PEAK_SPEED:  r_min_peak_sq <= cfg_sq;
                    gswc_pkg::REG_MIN_ANGLE:       r_min_angle   <= i_cfg_data;
                    default: begin
                        r_min_angle <= r_min_angle;
                    end
                endcase
            end
        end
    end

endmodule
